// ===== rtl/core/dtfp_pkg.sv =====
// Shared types and constants for the delimited text field parser.
// No dependencies; the top level refers to it by scoped names.
package dtfp_pkg;

  // Result kinds carried on the output channel.
  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_ROW_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  // Fixed character codes.
  localparam logic [7:0] QUOTE_CHAR   = 8'h22;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] DELIM_RESET  = 8'd44;

  // Parser context carried from one character to the next.
  typedef struct packed {
    logic in_quotes;
    logic quote_pending;
    logic field_has_content;
    logic row_has_fields;
  } parse_state_t;

  // One result beat.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } result_t;

endpackage

// ===== rtl/core/dtfp_in_if.sv =====
// Input channel of the delimited text field parser: one character or end mark per beat.
// Depends on nothing; used by delimited_text_field_parser_top.
interface dtfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

// ===== rtl/core/dtfp_out_if.sv =====
// Result channel of the delimited text field parser: one parse event per beat.
// Depends on nothing; used by delimited_text_field_parser_top.
interface dtfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// ===== rtl/core/delimited_text_field_parser_top.sv =====
// Top level of the delimited text field parser (CSV-style quoting, configurable delimiter).
// Depends on dtfp_pkg, dtfp_in_if and dtfp_out_if.
//
//   Channel   Direction  Beat contents
//   in_chan   in         ch[7:0], end_of_input
//   out_chan  out        kind[1:0], data_byte[7:0]
//   cfg_*     in         cfg_we, cfg_wdata[7:0] (field delimiter)
//
// One input beat is taken per cycle while in_chan.ready is high. The parse context is
// four flip-flops that update in the cycle a beat is accepted, so throughput is one
// character per clock while ready is high; each result is registered on its way to out_chan.
// A two-entry output stage (result register plus skid register) lets the input keep
// flowing while out_chan is stalled; in_chan.ready drops only when both
// entries are full. rst_n is synchronous and active low; it restores the delimiter
// to a comma and clears the parse context and both output entries.
module delimited_text_field_parser_top (
  input  logic              clk,
  input  logic              rst_n,
  dtfp_in_if.sink           in_chan,
  dtfp_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  // Configuration register.
  logic [7:0] delim_r;

  // Parse context.
  dtfp_pkg::parse_state_t state_r;
  dtfp_pkg::parse_state_t state_nxt;

  // Output stage: the register that drives out_chan and a skid entry behind it.
  logic                   out_vld_r;
  logic                   out_vld_nxt;
  dtfp_pkg::result_t      out_res_r;
  dtfp_pkg::result_t      out_res_nxt;
  logic                   skid_vld_r;
  logic                   skid_vld_nxt;
  dtfp_pkg::result_t      skid_res_r;
  dtfp_pkg::result_t      skid_res_nxt;

  // Result of the character currently offered on in_chan.
  logic                   res_vld;
  dtfp_pkg::result_t      res;

  logic                   accept;
  logic                   push;
  logic                   pop;

  assign in_chan.ready = !skid_vld_r;
  assign accept        = in_chan.valid && in_chan.ready;
  assign push          = accept && res_vld;
  assign pop           = out_vld_r && out_chan.ready;

  assign out_chan.valid     = out_vld_r;
  assign out_chan.kind      = out_res_r.kind;
  assign out_chan.data_byte = out_res_r.data_byte;

  // Parse step. A character that follows a pending quote and is not a second
  // quote closes the quoted field and is then treated like any unquoted character,
  // which is what the plain flag routes to the lower half of this block.
  always_comb begin
    logic       plain;
    logic [7:0] c;
    plain     = 1'b0;
    c         = in_chan.ch;
    state_nxt = state_r;
    res_vld   = 1'b0;
    res.kind  = dtfp_pkg::KIND_BYTE;
    res.data_byte = 8'd0;

    if (in_chan.end_of_input) begin
      // End of source: report what is left open and start a fresh stream.
      state_nxt = '0;
      if (state_r.quote_pending) begin
        res_vld  = 1'b1;
        res.kind = dtfp_pkg::KIND_ROW_END;
      end else if (state_r.in_quotes) begin
        res_vld  = 1'b1;
        res.kind = dtfp_pkg::KIND_ERROR;
      end else if (state_r.field_has_content || state_r.row_has_fields) begin
        res_vld  = 1'b1;
        res.kind = dtfp_pkg::KIND_ROW_END;
      end
    end else if (state_r.quote_pending) begin
      state_nxt.quote_pending = 1'b0;
      if (c == dtfp_pkg::QUOTE_CHAR) begin
        // Doubled quote: one literal quote, still inside the quoted field.
        state_nxt.field_has_content = 1'b1;
        res_vld       = 1'b1;
        res.data_byte = dtfp_pkg::QUOTE_CHAR;
      end else begin
        state_nxt.in_quotes = 1'b0;
        plain = 1'b1;
      end
    end else if (state_r.in_quotes) begin
      if (c == dtfp_pkg::QUOTE_CHAR) begin
        state_nxt.quote_pending = 1'b1;
      end else begin
        state_nxt.field_has_content = 1'b1;
        res_vld       = 1'b1;
        res.data_byte = c;
      end
    end else begin
      plain = 1'b1;
    end

    if (plain) begin
      if (c == dtfp_pkg::QUOTE_CHAR) begin
        // A quote opens a quoted field only at the start of a field.
        if (!state_nxt.field_has_content) begin
          state_nxt.in_quotes = 1'b1;
        end else begin
          res_vld       = 1'b1;
          res.data_byte = c;
        end
      end else if (c == delim_r) begin
        state_nxt.field_has_content = 1'b0;
        state_nxt.row_has_fields    = 1'b1;
        res_vld  = 1'b1;
        res.kind = dtfp_pkg::KIND_FIELD_END;
      end else if (c == dtfp_pkg::NEWLINE_CHAR) begin
        state_nxt = '0;
        res_vld   = 1'b1;
        res.kind  = dtfp_pkg::KIND_ROW_END;
      end else begin
        state_nxt.field_has_content = 1'b1;
        res_vld       = 1'b1;
        res.data_byte = c;
      end
    end
  end

  // Output stage. The skid entry only fills while the result register is stalled,
  // and it always moves forward before any newer result, so order is kept.
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    if (pop || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end else if (push) begin
        out_vld_nxt = 1'b1;
        out_res_nxt = res;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r    <= dtfp_pkg::DELIM_RESET;
      state_r    <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        delim_r <= cfg_wdata;
      end
      if (accept) begin
        state_r <= state_nxt;
      end
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  // The skid entry is only ever occupied behind a full result register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry valid while result register empty");

  // A pending quote can only exist inside a quoted field.
  a_pending_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.quote_pending |-> state_r.in_quotes)
    else $error("quote pending outside a quoted field");

  // End of input always leaves a clean parse context.
  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.end_of_input) |=> (state_r == '0))
    else $error("parse context not cleared after end of input");

  // An error result is only produced by an end-of-input beat.
  a_error_from_eoi: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.kind == dtfp_pkg::KIND_ERROR) |-> in_chan.end_of_input)
    else $error("unterminated quote reported without end of input");

endmodule
